/* src/hsl2rgb_pkg.sv */
`default_nettype none

package hsl2rgb_pkg;

   localparam int FIELD_W       = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int STAGES        = 5;

   // hue ramp segment of one channel
   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_HIGH,
      SEG_FALL,
      SEG_LOW
   } ramp_seg_type;

   // load enables of the pipeline stages, stage 1 first
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

`default_nettype wire

/* src/hsl2rgb_req_if.sv */
`default_nettype none

interface hsl2rgb_req_if import hsl2rgb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] hue;
   logic [FIELD_W-1:0] saturation;
   logic [FIELD_W-1:0] lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

`default_nettype wire

/* src/hsl2rgb_rsp_if.sv */
`default_nettype none

interface hsl2rgb_rsp_if import hsl2rgb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] red;
   logic [FIELD_W-1:0] green;
   logic [FIELD_W-1:0] blue;

   modport source (output valid, output red, output green, output blue,
                   input ready);
   modport sink   (input valid, input red, input green, input blue,
                   output ready);
endinterface

`default_nettype wire

/* src/hsl2rgb_ramp.sv */
`default_nettype none

module hsl2rgb_ramp import hsl2rgb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire stage_en_type         stage_en,
   input  wire logic [FRAC_BITS-1:0] hue_off,
   input  wire logic [FRAC_BITS:0]   diff,
   input  wire logic [FRAC_BITS:0]   lo_lvl,
   input  wire logic [FRAC_BITS:0]   hi_lvl,
   input  wire logic [FRAC_BITS-1:0] grey_lvl,
   input  wire logic                 grey,
   output logic      [FIELD_W-1:0]   chan
);

   localparam int F  = FRAC_BITS;
   localparam int TW = F + 3;
   localparam int VW = F + 2;
   localparam int TOPV = (F < FIELD_W) ? ((1 << F) - 1) : ((1 << FIELD_W) - 1);
   localparam logic [TW-1:0] ONE_T  = TW'(1) << F;
   localparam logic [VW-1:0] TWO_V  = VW'(1) << (F + 1);
   localparam logic [VW-1:0] TOP_V  = VW'(TOPV);

   logic [TW-1:0]  six_t;
   logic [VW-1:0]  three_t;
   ramp_seg_type   seg2_in, seg2_ff, seg3_ff, seg4_ff;
   logic [F:0]     fac2_in, fac2_ff, fac3_ff;
   logic [2*F+1:0] prod4_in, prod4_ff;
   logic [VW-1:0]  val;
   logic [FIELD_W-1:0] chan5_in, chan5_ff;

   // segment of the hue ramp and slope factor
   always_comb begin
      six_t   = (TW'(hue_off) << 2) + (TW'(hue_off) << 1);
      three_t = (VW'(hue_off) << 1) + VW'(hue_off);
      fac2_in = (F + 1)'(six_t);
      if (six_t < ONE_T) begin
         seg2_in = SEG_RISE;
      end else if (!hue_off[F-1]) begin
         seg2_in = SEG_HIGH;
      end else if (three_t < TWO_V) begin
         seg2_in = SEG_FALL;
         fac2_in = (F + 1)'((ONE_T << 2) - six_t);
      end else begin
         seg2_in = SEG_LOW;
      end
   end

   assign prod4_in = diff * fac3_ff;

   always_comb begin
      case (seg4_ff)
         SEG_RISE, SEG_FALL: val = VW'(lo_lvl) + prod4_ff[2*F+1:F];
         SEG_HIGH:           val = VW'(hi_lvl);
         default:            val = VW'(lo_lvl);
      endcase
      if (grey) begin
         val = VW'(grey_lvl);
      end
      if (val > TOP_V) begin
         val = TOP_V;
      end
      chan5_in = FIELD_W'(val);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         seg2_ff <= seg2_in;
         fac2_ff <= fac2_in;
      end
      if (stage_en.s3) begin
         seg3_ff <= seg2_ff;
         fac3_ff <= fac2_ff;
      end
      if (stage_en.s4) begin
         seg4_ff  <= seg3_ff;
         prod4_ff <= prod4_in;
      end
      if (stage_en.s5) begin
         chan5_ff <= chan5_in;
      end
   end

   assign chan = chan5_ff;

endmodule

`default_nettype wire

/* src/hsl_to_rgb_converter_unit.sv */
`default_nettype none

// HSL to RGB conversion in unsigned Q0.FRAC_BITS fixed point. A request
// carries hue, saturation and lightness; the response carries red, green and
// blue, saturated at the smaller of 1.0 - 1 LSB and 65535. Zero saturation
// gives grey at the lightness value. The datapath is a five-stage pipeline:
// input clamp and hue offsets, the lightness-saturation product with the ramp
// segment decode, the p/q levels, one ramp product per channel, and the
// final add and clamp into the output register. One request is taken every
// clock cycle unless a stalled response holds the pipeline back to the input
// stage; a stalled response holds only the stages behind it that are full,
// so bubbles are squeezed out.

module hsl_to_rgb_converter_unit import hsl2rgb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input wire logic      clock,
   input wire logic      reset,
   hsl2rgb_req_if.sink   req_chan,
   hsl2rgb_rsp_if.source rsp_chan
);

   localparam int F  = FRAC_BITS;
   localparam int XW = (F > FIELD_W) ? F : FIELD_W;
   localparam logic [F-1:0]  MAXV  = {F{1'b1}};
   localparam logic [XW-1:0] MAXV_X = XW'(MAXV);
   localparam logic [F-1:0]  THIRD = F'((1 << F) / 3);

   logic [STAGES-1:0] vld_ff, vld_in;
   stage_en_type      stage_en;

   logic [XW-1:0] hue_x, sat_x, lit_x;
   logic [F-1:0]  h1_in, s1_in, l1_in, h1_ff, s1_ff, l1_ff;
   logic [F-1:0]  off_r, off_g, off_b;
   logic [2*F-1:0] ls_full;
   logic [F-1:0]  ls2_in, ls2_ff, s2_ff, l2_ff;
   logic          grey2_in, grey2_ff, grey3_ff, grey4_ff;
   logic [F:0]    q3_in, p3_in, d3_in, q3_ff, p3_ff, d3_ff, q4_ff, p4_ff;
   logic [F-1:0]  l3_ff, l4_ff;
   logic [F+1:0]  q_hi, p_hi;

   // stage load enables, a stage moves when empty or when its successor moves
   always_comb begin
      stage_en.s5 = !vld_ff[4] || rsp_chan.ready;
      stage_en.s4 = !vld_ff[3] || stage_en.s5;
      stage_en.s3 = !vld_ff[2] || stage_en.s4;
      stage_en.s2 = !vld_ff[1] || stage_en.s3;
      stage_en.s1 = !vld_ff[0] || stage_en.s2;
      vld_in[0] = stage_en.s1 ? req_chan.valid : vld_ff[0];
      vld_in[1] = stage_en.s2 ? vld_ff[0] : vld_ff[1];
      vld_in[2] = stage_en.s3 ? vld_ff[1] : vld_ff[2];
      vld_in[3] = stage_en.s4 ? vld_ff[2] : vld_ff[3];
      vld_in[4] = stage_en.s5 ? vld_ff[3] : vld_ff[4];
   end

   assign req_chan.ready = stage_en.s1;
   assign rsp_chan.valid = vld_ff[4];

   // input clamp, hue wraps
   always_comb begin
      hue_x = XW'(req_chan.hue);
      sat_x = XW'(req_chan.saturation);
      lit_x = XW'(req_chan.lightness);
      h1_in = hue_x[F-1:0];
      s1_in = (sat_x > MAXV_X) ? MAXV : sat_x[F-1:0];
      l1_in = (lit_x > MAXV_X) ? MAXV : lit_x[F-1:0];
   end

   assign off_r = h1_ff + THIRD;
   assign off_g = h1_ff;
   assign off_b = h1_ff - THIRD;

   assign ls_full  = l1_ff * s1_ff;
   assign ls2_in   = ls_full[2*F-1:F];
   assign grey2_in = (s1_ff == '0);

   // q and p levels, and their difference
   always_comb begin
      if (!l2_ff[F-1]) begin
         q_hi  = (F + 2)'(l2_ff) + (F + 2)'(ls2_ff);
         p_hi  = (F + 2)'(l2_ff) - (F + 2)'(ls2_ff);
         q3_in = q_hi[F:0];
         p3_in = p_hi[F:0];
         d3_in = (F + 1)'(ls2_ff) << 1;
      end else begin
         q_hi  = (F + 2)'(l2_ff) + (F + 2)'(s2_ff) - (F + 2)'(ls2_ff);
         p_hi  = (F + 2)'(l2_ff) + (F + 2)'(ls2_ff) - (F + 2)'(s2_ff);
         q3_in = q_hi[F:0];
         if (p_hi[F+1]) begin
            p3_in = '0;
            d3_in = q_hi[F:0];
         end else begin
            p3_in = p_hi[F:0];
            d3_in = (F + 1)'(s2_ff - ls2_ff) << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         h1_ff <= h1_in;
         s1_ff <= s1_in;
         l1_ff <= l1_in;
      end
      if (stage_en.s2) begin
         ls2_ff   <= ls2_in;
         s2_ff    <= s1_ff;
         l2_ff    <= l1_ff;
         grey2_ff <= grey2_in;
      end
      if (stage_en.s3) begin
         q3_ff    <= q3_in;
         p3_ff    <= p3_in;
         d3_ff    <= d3_in;
         l3_ff    <= l2_ff;
         grey3_ff <= grey2_ff;
      end
      if (stage_en.s4) begin
         q4_ff    <= q3_ff;
         p4_ff    <= p3_ff;
         l4_ff    <= l3_ff;
         grey4_ff <= grey3_ff;
      end
   end

   hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_red (
      .clock    (clock),
      .stage_en (stage_en),
      .hue_off  (off_r),
      .diff     (d3_ff),
      .lo_lvl   (p4_ff),
      .hi_lvl   (q4_ff),
      .grey_lvl (l4_ff),
      .grey     (grey4_ff),
      .chan     (rsp_chan.red)
   );

   hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_green (
      .clock    (clock),
      .stage_en (stage_en),
      .hue_off  (off_g),
      .diff     (d3_ff),
      .lo_lvl   (p4_ff),
      .hi_lvl   (q4_ff),
      .grey_lvl (l4_ff),
      .grey     (grey4_ff),
      .chan     (rsp_chan.green)
   );

   hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_blue (
      .clock    (clock),
      .stage_en (stage_en),
      .hue_off  (off_b),
      .diff     (d3_ff),
      .lo_lvl   (p4_ff),
      .hi_lvl   (q4_ff),
      .grey_lvl (l4_ff),
      .grey     (grey4_ff),
      .chan     (rsp_chan.blue)
   );

endmodule

`default_nettype wire
